// ===== sv/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// Types, constants and codes shared by the WAVE header parser modules.
// ----------------------------------------------------------------------------
package whp_pkg;

    localparam int POSITION_BITS   = 32;
    localparam int FMT_CHUNK_BYTES = 16;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666d7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    typedef enum logic [2:0] {
        PH_RIFF_TAG,
        PH_RIFF_SIZE,
        PH_WAVE_TAG,
        PH_CHUNK_TAG,
        PH_CHUNK_SIZE,
        PH_FMT_BODY,
        PH_SKIP,
        PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_RIFF,
        ST_NOT_WAVE,
        ST_FMT_SIZE_BAD,
        ST_NOT_PCM,
        ST_CHANNELS_BAD,
        ST_NO_FMT,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
        logic [31:0] data_offset;
    } out_beat_t;

    // Handshake between the input register, the parser and the result register.
    typedef struct packed {
        logic beat_valid;
        logic advance;
    } step_ctrl_t;

endpackage

// ===== sv/whp_in_reg.sv =====
// ----------------------------------------------------------------------------
// whp_in_reg
// Input register: holds one accepted byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module whp_in_reg import whp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    input  logic     advance,
    output logic     beat_valid,
    output in_beat_t beat
);

    logic     valid_reg, valid_next;
    in_beat_t beat_reg;
    logic     load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= s_data;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ===== sv/whp_core.sv =====
// ----------------------------------------------------------------------------
// whp_core
// Parser state and the combinational update for one file byte.
// ----------------------------------------------------------------------------
module whp_core import whp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  step_ctrl_t ctrl,
    input  in_beat_t   beat,
    output logic       res_valid,
    output out_beat_t  res
);

    phase_t                   phase_reg, phase_next;
    logic [3:0]               fbi_reg, fbi_next;
    logic [31:0]              tag_reg, tag_next;
    logic [31:0]              size_reg, size_next;
    logic [31:0]              skip_reg, skip_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     fmt_seen_reg, fmt_seen_next;
    logic [1:0]               chan_reg, chan_next;
    logic [31:0]              rate_reg, rate_next;
    logic [15:0]              bits_reg, bits_next;
    logic                     given_reg, given_next;

    logic [3:0]  fbi_inc;
    logic [3:0]  field_start;
    logic [1:0]  lane;
    logic [31:0] lane_val;
    logic [31:0] fmt_val;
    logic        give;
    status_t     give_status;

    // Offset in the fmt body at which the field holding byte idx begins.
    function automatic logic [3:0] fmt_field_start(input logic [3:0] idx);
        logic [3:0] s;
        if (idx < 4'd2) begin
            s = 4'd0;
        end else if (idx < 4'd4) begin
            s = 4'd2;
        end else if (idx < 4'd8) begin
            s = 4'd4;
        end else if (idx < 4'd12) begin
            s = 4'd8;
        end else if (idx < 4'd14) begin
            s = 4'd12;
        end else begin
            s = 4'd14;
        end
        return s;
    endfunction

    assign fbi_inc     = fbi_reg + 4'd1;
    assign field_start = fmt_field_start(fbi_reg);
    assign lane        = (phase_reg == PH_FMT_BODY) ? 2'(fbi_reg - field_start)
                                                    : fbi_reg[1:0];
    assign lane_val    = 32'(beat.file_byte) << {lane, 3'b000};
    assign fmt_val     = ((fbi_reg == field_start) ? 32'd0 : size_reg) | lane_val;

    always_comb begin
        phase_next    = phase_reg;
        fbi_next      = fbi_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        skip_next     = skip_reg;
        fmt_seen_next = fmt_seen_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        given_next    = given_reg;
        give          = 1'b0;
        give_status   = ST_OK;
        pos_next      = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        case (phase_reg)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_TAG: begin
                tag_next = {tag_reg[23:0], beat.file_byte};
                fbi_next = fbi_inc;
                if (fbi_inc == 4'd4) begin
                    fbi_next = 4'd0;
                    if (phase_reg == PH_RIFF_TAG) begin
                        if (tag_next != TAG_RIFF) begin
                            give        = 1'b1;
                            give_status = ST_NOT_RIFF;
                        end else begin
                            phase_next = PH_RIFF_SIZE;
                        end
                    end else if (phase_reg == PH_WAVE_TAG) begin
                        if (tag_next != TAG_WAVE) begin
                            give        = 1'b1;
                            give_status = ST_NOT_WAVE;
                        end else begin
                            phase_next = PH_CHUNK_TAG;
                        end
                    end else begin
                        size_next  = 32'd0;
                        phase_next = PH_CHUNK_SIZE;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                fbi_next = fbi_inc;
                if (fbi_inc == 4'd4) begin
                    fbi_next   = 4'd0;
                    phase_next = PH_WAVE_TAG;
                end
            end
            PH_CHUNK_SIZE: begin
                size_next = size_reg | lane_val;
                fbi_next  = fbi_inc;
                if (fbi_inc == 4'd4) begin
                    fbi_next = 4'd0;
                    if (tag_reg == TAG_FMT) begin
                        if (size_next != 32'(FMT_CHUNK_BYTES)) begin
                            give        = 1'b1;
                            give_status = ST_FMT_SIZE_BAD;
                        end else begin
                            size_next  = 32'd0;
                            phase_next = PH_FMT_BODY;
                        end
                    end else if (tag_reg == TAG_DATA) begin
                        give        = 1'b1;
                        give_status = fmt_seen_reg ? ST_OK : ST_NO_FMT;
                    end else begin
                        skip_next  = size_next;
                        phase_next = (size_next != 32'd0) ? PH_SKIP : PH_CHUNK_TAG;
                    end
                end
            end
            PH_FMT_BODY: begin
                size_next = fmt_val;
                if (fbi_reg == 4'd1 && fmt_val != 32'd1) begin
                    give        = 1'b1;
                    give_status = ST_NOT_PCM;
                    fbi_next    = 4'd0;
                end else if (fbi_reg == 4'd3 && fmt_val != 32'd1 && fmt_val != 32'd2) begin
                    give        = 1'b1;
                    give_status = ST_CHANNELS_BAD;
                    fbi_next    = 4'd0;
                end else begin
                    if (fbi_reg == 4'd3) begin
                        chan_next = fmt_val[1:0];
                    end
                    if (fbi_reg == 4'd7) begin
                        rate_next = fmt_val;
                    end
                    if (fbi_reg == 4'(FMT_CHUNK_BYTES - 1)) begin
                        bits_next     = fmt_val[15:0];
                        fmt_seen_next = 1'b1;
                        fbi_next      = 4'd0;
                        phase_next    = PH_CHUNK_TAG;
                    end else begin
                        fbi_next = fbi_inc;
                    end
                end
            end
            PH_SKIP: begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0) begin
                    phase_next = PH_CHUNK_TAG;
                end
            end
            default: begin
            end
        endcase

        if (give) begin
            given_next = 1'b1;
            phase_next = PH_IDLE;
        end

        // The final byte closes the file: a file with no verdict yet is
        // reported as truncated.
        if (beat.last_byte && !give && !given_reg) begin
            give        = 1'b1;
            give_status = ST_TRUNCATED;
        end

        res_valid = ctrl.advance && give;
        res       = '0;
        res.status = give_status;
        if (give_status == ST_OK) begin
            res.channel_count = chan_reg;
            res.sample_rate   = rate_reg;
            res.sample_bits   = bits_reg;
            res.data_size     = size_next;
            res.data_offset   = 32'(pos_next);
        end

        if (beat.last_byte) begin
            phase_next    = PH_RIFF_TAG;
            fbi_next      = 4'd0;
            tag_next      = 32'd0;
            size_next     = 32'd0;
            skip_next     = 32'd0;
            pos_next      = '0;
            fmt_seen_next = 1'b0;
            chan_next     = 2'd0;
            rate_next     = 32'd0;
            bits_next     = 16'd0;
            given_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_RIFF_TAG;
            fbi_reg      <= 4'd0;
            tag_reg      <= 32'd0;
            size_reg     <= 32'd0;
            skip_reg     <= 32'd0;
            pos_reg      <= '0;
            fmt_seen_reg <= 1'b0;
            chan_reg     <= 2'd0;
            rate_reg     <= 32'd0;
            bits_reg     <= 16'd0;
            given_reg    <= 1'b0;
        end else if (ctrl.advance && ctrl.beat_valid) begin
            phase_reg    <= phase_next;
            fbi_reg      <= fbi_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            skip_reg     <= skip_next;
            pos_reg      <= pos_next;
            fmt_seen_reg <= fmt_seen_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
            given_reg    <= given_next;
        end
    end

endmodule

// ===== sv/whp_out_reg.sv =====
// ----------------------------------------------------------------------------
// whp_out_reg
// Result register: holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module whp_out_reg import whp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      res_valid,
    input  out_beat_t res,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      valid_reg, valid_next;
    out_beat_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== sv/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_header_parser
// Streaming checker for the header of a RIFF/WAVE PCM file, one byte a beat,
// giving one result beat per file.
// ----------------------------------------------------------------------------
//  channel   direction  payload     handshake
//  s_        in         in_beat_t   s_valid / s_ready
//  m_        out        out_beat_t  m_valid / m_ready
//
// One byte beat is accepted per cycle while the parser is not stalled; it is
// parsed from the input register, and its result (if any) is loaded into the
// result register at the end of the cycle in which that byte is parsed.
// Reset (aresetn low, synchronous) returns the parser to the RIFF tag and
// empties both registers. A result waiting in the result register stalls
// parsing, and the input register then stops accepting once it is full.
module wav_header_parser import whp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    step_ctrl_t ctrl;
    in_beat_t   beat;
    logic       beat_valid;
    logic       res_valid;
    out_beat_t  res;

    assign ctrl.beat_valid = beat_valid;
    assign ctrl.advance    = beat_valid && (!m_valid || m_ready);

    whp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (ctrl.advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    whp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    whp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
